// ----- hdl/dps_pkg.sv -----
`timescale 1ns / 1ps

package dps_pkg;

    // field widths
    localparam int COUNT_W = 32;
    localparam int IR_W    = 12;
    localparam int MODE_W  = 2;
    localparam int SPEED_W = 8;
    localparam int GAIN_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // datapath widths
    localparam int ERR_W  = 32;
    localparam int WALL_W = IR_W + 1;
    localparam int PROD_W = GAIN_W + ERR_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 3;

    // fixed gain scale, a power of two so the divide is a biased shift
    localparam int GAIN_SCALE = 256;
    localparam int GAIN_SHIFT = $clog2(GAIN_SCALE);
    localparam int QUOT_W     = SUM_W - GAIN_SHIFT;

    localparam logic [SPEED_W-1:0] SPEED_MIN = SPEED_W'(55);
    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(255);

    // wall following modes
    localparam logic [MODE_W-1:0] WALL_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] WALL_LEFT  = 2'd1;
    localparam logic [MODE_W-1:0] WALL_RIGHT = 2'd2;
    localparam logic [MODE_W-1:0] WALL_BOTH  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_VEL_P  = 3'd0,
        CFG_GAIN_VEL_D  = 3'd1,
        CFG_GAIN_ANG_P  = 3'd2,
        CFG_GAIN_ANG_D  = 3'd3,
        CFG_GAIN_WALL_P = 3'd4,
        CFG_GAIN_WALL_D = 3'd5,
        CFG_BASE_SPEED  = 3'd6,
        CFG_WALL_TARGET = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COUNT_W-1:0] left_count;
        logic signed [COUNT_W-1:0] right_count;
        logic        [IR_W-1:0]    left_ir;
        logic        [IR_W-1:0]    right_ir;
        logic        [MODE_W-1:0]  wall_mode;
    } t_in_item;

    typedef struct packed {
        logic [SPEED_W-1:0] left_speed;
        logic [SPEED_W-1:0] right_speed;
    } t_out_item;

endpackage

// ----- hdl/differential_drive_pd_steering_core.sv -----
`timescale 1ns / 1ps
// PD steering for a two-wheeled drive with optional wall following.
// Input channel (i_in_valid / o_in_ready, i_in_data) carries one sensor sample
// per control tick: both cumulative encoder counts, both side IR readings and
// the wall mode. Output channel (o_out_valid / i_out_ready, o_out_data) returns
// one pair of wheel drive values per sample, in order.
// Throughput is one sample per cycle while the receiver keeps up: six pipeline stages (errors, products,
// pair sums, total, scaled control, clamped speeds), each with its own valid
// bit. A stage loads whenever it is empty or its successor loads, so bubbles
// close up and input keeps flowing while a finished result waits.
// Encoder history and previous errors update at the input transfer, so the
// next sample may follow in the very next cycle.
// If the receiver stalls, the result holds steady and the pipeline fills;
// o_in_ready drops only once every stage is occupied.
// Reset (synchronous, active low) empties the pipeline, clears the history
// and sets all gains, base speed and wall target to zero.
// Configuration is written via i_cfg_we / i_cfg_idx / i_cfg_data, one register
// per cycle; the user must do so only while no sample is in flight (unchecked).

module differential_drive_pd_steering_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  dps_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output dps_pkg::t_out_item          o_out_data,
    input  logic                        i_cfg_we,
    input  logic [dps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dps_pkg::CFG_W-1:0]   i_cfg_data
);
    import dps_pkg::*;

    localparam int STAGES = 6;

    // configuration
    logic signed [GAIN_W-1:0] r_gain_vp, r_gain_vd, r_gain_ap, r_gain_ad;
    logic signed [GAIN_W-1:0] r_gain_wp, r_gain_wd;
    logic [SPEED_W-1:0]       r_base_speed;
    logic [IR_W-1:0]          r_wall_target;

    // history
    logic [COUNT_W-1:0] r_last_left, r_last_right;
    logic [ERR_W-1:0]   r_last_vel_err, r_last_ang_err, r_last_wall_err;

    // pipeline control
    logic [STAGES-1:0] r_v;
    logic [STAGES:0]   adv;
    logic              in_xfer;

    // stage 1 .. 6 payload
    logic signed [ERR_W-1:0]  r_vel_err, r_vel_der, r_ang_err, r_ang_der;
    logic signed [ERR_W-1:0]  r_wall_err, r_wall_der;
    logic signed [PROD_W-1:0] r_p_vp, r_p_vd, r_p_ap, r_p_ad, r_p_wp, r_p_wd;
    logic signed [PAIR_W-1:0] r_pair_v, r_pair_a, r_pair_w;
    logic signed [SUM_W-1:0]  r_total;
    logic signed [ERR_W-1:0]  r_ctrl;
    t_out_item                r_out;

    // stage 1 next values
    logic [COUNT_W-1:0]       n_vel_l, n_vel_r;
    logic [ERR_W-1:0]         n_vel_err, n_vel_der, n_ang_err, n_ang_der;
    logic signed [WALL_W-1:0] n_wall;
    logic [ERR_W-1:0]         n_wall_err, n_wall_der;

    // stage 5 and 6 next values
    logic signed [SUM_W-1:0]  n_biased;
    logic signed [QUOT_W-1:0] n_quot;
    logic                     n_fits;
    logic signed [ERR_W-1:0]  n_ctrl;
    logic signed [ERR_W+1:0]  n_left, n_right, base_ext, ctrl_ext;
    t_out_item                n_out;

    // a stage loads when it is empty or its successor loads
    always_comb begin
        adv[STAGES] = i_out_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_in_ready  = adv[0];
    assign in_xfer     = i_in_valid && adv[0];
    assign o_out_valid = r_v[STAGES-1];
    assign o_out_data  = r_out;

    // error terms, all modulo 2^32
    always_comb begin
        n_vel_l    = i_in_data.left_count - r_last_left;
        n_vel_r    = i_in_data.right_count - r_last_right;
        n_vel_err  = n_vel_r - n_vel_l;
        n_vel_der  = n_vel_err - r_last_vel_err;
        n_ang_err  = i_in_data.right_count - i_in_data.left_count;
        n_ang_der  = n_ang_err - r_last_ang_err;
        case (i_in_data.wall_mode)
            WALL_LEFT:  n_wall = $signed({1'b0, r_wall_target}) -
                                 $signed({1'b0, i_in_data.left_ir});
            WALL_RIGHT: n_wall = $signed({1'b0, i_in_data.right_ir}) -
                                 $signed({1'b0, r_wall_target});
            WALL_BOTH:  n_wall = $signed({1'b0, i_in_data.right_ir}) -
                                 $signed({1'b0, i_in_data.left_ir});
            default:    n_wall = '0;
        endcase
        n_wall_err = {{(ERR_W-WALL_W){n_wall[WALL_W-1]}}, n_wall};
        n_wall_der = n_wall_err - r_last_wall_err;
    end

    // divide by the scale truncating toward zero, then saturate to 32 bits
    always_comb begin
        n_biased = r_total + (r_total[SUM_W-1] ? SUM_W'(GAIN_SCALE - 1) : '0);
        n_quot   = QUOT_W'(n_biased >>> GAIN_SHIFT);
        n_fits   = (n_quot[QUOT_W-1:ERR_W-1] == '0) || (&n_quot[QUOT_W-1:ERR_W-1]);
        if (n_fits) begin
            n_ctrl = n_quot[ERR_W-1:0];
        end else if (n_quot[QUOT_W-1]) begin
            n_ctrl = {1'b1, {(ERR_W-1){1'b0}}};
        end else begin
            n_ctrl = {1'b0, {(ERR_W-1){1'b1}}};
        end
    end

    // wheel speeds, exact sums clamped to the drive range
    always_comb begin
        base_ext = $signed({{(ERR_W+2-SPEED_W){1'b0}}, r_base_speed});
        ctrl_ext = {{2{r_ctrl[ERR_W-1]}}, r_ctrl};
        n_left   = base_ext + ctrl_ext;
        n_right  = base_ext - ctrl_ext;
        if (n_left < $signed({{(ERR_W+2-SPEED_W){1'b0}}, SPEED_MIN})) begin
            n_out.left_speed = SPEED_MIN;
        end else if (n_left > $signed({{(ERR_W+2-SPEED_W){1'b0}}, SPEED_MAX})) begin
            n_out.left_speed = SPEED_MAX;
        end else begin
            n_out.left_speed = n_left[SPEED_W-1:0];
        end
        if (n_right < $signed({{(ERR_W+2-SPEED_W){1'b0}}, SPEED_MIN})) begin
            n_out.right_speed = SPEED_MIN;
        end else if (n_right > $signed({{(ERR_W+2-SPEED_W){1'b0}}, SPEED_MAX})) begin
            n_out.right_speed = SPEED_MAX;
        end else begin
            n_out.right_speed = n_right[SPEED_W-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_vp     <= '0;
            r_gain_vd     <= '0;
            r_gain_ap     <= '0;
            r_gain_ad     <= '0;
            r_gain_wp     <= '0;
            r_gain_wd     <= '0;
            r_base_speed  <= '0;
            r_wall_target <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_VEL_P:  r_gain_vp     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_VEL_D:  r_gain_vd     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_ANG_P:  r_gain_ap     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_ANG_D:  r_gain_ad     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_WALL_P: r_gain_wp     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_WALL_D: r_gain_wd     <= i_cfg_data[GAIN_W-1:0];
                CFG_BASE_SPEED:  r_base_speed  <= i_cfg_data[SPEED_W-1:0];
                CFG_WALL_TARGET: r_wall_target <= i_cfg_data[IR_W-1:0];
                default: ;
            endcase
        end
    end

    // history and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v             <= '0;
            r_last_left     <= '0;
            r_last_right    <= '0;
            r_last_vel_err  <= '0;
            r_last_ang_err  <= '0;
            r_last_wall_err <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (in_xfer) begin
                r_last_left     <= i_in_data.left_count;
                r_last_right    <= i_in_data.right_count;
                r_last_vel_err  <= n_vel_err;
                r_last_ang_err  <= n_ang_err;
                r_last_wall_err <= n_wall_err;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_vel_err  <= n_vel_err;
            r_vel_der  <= n_vel_der;
            r_ang_err  <= n_ang_err;
            r_ang_der  <= n_ang_der;
            r_wall_err <= n_wall_err;
            r_wall_der <= n_wall_der;
        end
        if (adv[1] && r_v[0]) begin
            r_p_vp <= r_gain_vp * r_vel_err;
            r_p_vd <= r_gain_vd * r_vel_der;
            r_p_ap <= r_gain_ap * r_ang_err;
            r_p_ad <= r_gain_ad * r_ang_der;
            r_p_wp <= r_gain_wp * r_wall_err;
            r_p_wd <= r_gain_wd * r_wall_der;
        end
        if (adv[2] && r_v[1]) begin
            r_pair_v <= PAIR_W'(r_p_vp) + PAIR_W'(r_p_vd);
            r_pair_a <= PAIR_W'(r_p_ap) + PAIR_W'(r_p_ad);
            r_pair_w <= PAIR_W'(r_p_wp) + PAIR_W'(r_p_wd);
        end
        if (adv[3] && r_v[2]) begin
            r_total <= SUM_W'(r_pair_v) + SUM_W'(r_pair_a) + SUM_W'(r_pair_w);
        end
        if (adv[4] && r_v[3]) begin
            r_ctrl <= n_ctrl;
        end
        if (adv[5] && r_v[4]) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- hdl/dps_checker.sv -----
`timescale 1ns / 1ps

module dps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input dps_pkg::t_out_item o_out_data
);
    import dps_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // both drive values stay at or above SPEED_MIN, the bottom of the motor range
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.left_speed >= SPEED_MIN) &&
                        (o_out_data.right_speed >= SPEED_MIN))
        else $error("drive value below minimum");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

    // with no result waiting the pipeline cannot be full
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

endmodule

bind differential_drive_pd_steering_core dps_checker u_dps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
